[rtl/adc_millivolt_ascii_reporter_assert.svh]
`ifndef ADC_MILLIVOLT_ASCII_REPORTER_ASSERT_SVH
`define ADC_MILLIVOLT_ASCII_REPORTER_ASSERT_SVH

// check the consequent in the same cycle as the antecedent
`define AMAR_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("amar assertion failed");

// check the consequent in the cycle after the antecedent
`define AMAR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("amar assertion failed");

`endif

[rtl/amar_pkg.sv]
package amar_pkg;

   localparam int unsigned ADC_W   = 16;
   localparam int unsigned FS_W    = 14;
   localparam int unsigned MV_W    = 14;
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned IDX_W   = 4;

   localparam logic [FS_W-1:0]   FS_RESET   = 14'd3300;
   localparam logic [MV_W-1:0]   MV_MAX     = 14'd9999;

   localparam logic [IDX_W-1:0]  POS_THOU   = 4'd8;
   localparam logic [IDX_W-1:0]  POS_HUND   = 4'd10;
   localparam logic [IDX_W-1:0]  POS_TENS   = 4'd11;
   localparam logic [IDX_W-1:0]  POS_UNITS  = 4'd12;
   localparam logic [IDX_W-1:0]  POS_LAST   = 4'd14;

   localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;

   typedef struct packed {
      logic            valid;
      logic [MV_W-1:0] mv;
   } amar_mv_type;

   // "Voltaje:0.000" CR LF
   function automatic logic [BYTE_W-1:0] template_char(input logic [IDX_W-1:0] pos);
      logic [BYTE_W-1:0] ch;
      case (pos)
         4'd0:    ch = 8'h56;
         4'd1:    ch = 8'h6F;
         4'd2:    ch = 8'h6C;
         4'd3:    ch = 8'h74;
         4'd4:    ch = 8'h61;
         4'd5:    ch = 8'h6A;
         4'd6:    ch = 8'h65;
         4'd7:    ch = 8'h3A;
         4'd8:    ch = 8'h30;
         4'd9:    ch = 8'h2E;
         4'd10:   ch = 8'h30;
         4'd11:   ch = 8'h30;
         4'd12:   ch = 8'h30;
         4'd13:   ch = 8'h0D;
         4'd14:   ch = 8'h0A;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

[rtl/amar_scaler.sv]
module amar_scaler
   import amar_pkg::*;
#(
   parameter int unsigned SAMPLE_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [ADC_W-1:0]  in_sample,
   input  logic [FS_W-1:0]   full_scale,
   output amar_mv_type       mv_out,
   input  logic              mv_ready
);

   localparam int unsigned PROD_W = SAMPLE_BITS + FS_W;
   localparam logic [PROD_W-1:0] DIVISOR = PROD_W'((64'd1 << SAMPLE_BITS) - 64'd1);
   localparam logic [PROD_W-1:0] DIVISOR2 = DIVISOR << 1;

   logic              s1_valid_ff, s1_valid_in;
   logic [PROD_W-1:0] s1_prod_ff, s1_prod_in;
   logic              s2_valid_ff, s2_valid_in;
   logic [PROD_W-1:0] s2_prod_ff;
   logic [FS_W-1:0]   s2_quot_ff, s2_quot_in;
   logic              s3_valid_ff, s3_valid_in;
   logic [MV_W-1:0]   s3_mv_ff, s3_mv_in;

   logic              s3_load, s2_load, s1_load;
   logic [PROD_W:0]   approx_sum;
   logic [PROD_W-1:0] quot_times_div;
   logic [PROD_W-1:0] remainder;
   logic [FS_W:0]     quot_fixed;

   assign s3_load  = s2_valid_ff && (!s3_valid_ff || mv_ready);
   assign s2_load  = s1_valid_ff && (!s2_valid_ff || s3_load);
   assign s1_load  = in_valid && in_ready;
   assign in_ready = !s1_valid_ff || s2_load;

   assign s1_valid_in = s1_load || (s1_valid_ff && !s2_load);
   assign s2_valid_in = s2_load || (s2_valid_ff && !s3_load);
   assign s3_valid_in = s3_load || (s3_valid_ff && !mv_ready);

   assign s1_prod_in = {{FS_W{1'b0}}, in_sample[SAMPLE_BITS-1:0]}
                     * {{SAMPLE_BITS{1'b0}}, full_scale};

   // divide by 2^n - 1: first estimate, short by at most two
   assign approx_sum = {1'b0, s1_prod_ff} + (PROD_W+1)'(s1_prod_ff >> SAMPLE_BITS);
   assign s2_quot_in = FS_W'(approx_sum >> SAMPLE_BITS);

   assign quot_times_div = (PROD_W'(s2_quot_ff) << SAMPLE_BITS) - PROD_W'(s2_quot_ff);
   assign remainder      = s2_prod_ff - quot_times_div;
   assign quot_fixed     = {1'b0, s2_quot_ff}
                         + (FS_W+1)'(remainder >= DIVISOR)
                         + (FS_W+1)'(remainder >= DIVISOR2);
   assign s3_mv_in = (quot_fixed > {1'b0, MV_MAX}) ? MV_MAX : quot_fixed[FS_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
      if (s1_load) begin
         s1_prod_ff <= s1_prod_in;
      end
      if (s2_load) begin
         s2_prod_ff <= s1_prod_ff;
         s2_quot_ff <= s2_quot_in;
      end
      if (s3_load) begin
         s3_mv_ff <= s3_mv_in;
      end
   end

   assign mv_out.valid = s3_valid_ff;
   assign mv_out.mv    = s3_mv_ff;

endmodule

[rtl/amar_serialiser.sv]
module amar_serialiser
   import amar_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  amar_mv_type        mv_in,
   output logic               mv_ready,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [BYTE_W-1:0]  rsp_tdata,
   output logic [IDX_W-1:0]   rsp_tuser,
   output logic               rsp_tlast
);

   localparam int unsigned RPROD_W = 2 * MV_W;
   localparam logic [MV_W-1:0] RECIP_THOU = 14'd8389;
   localparam logic [MV_W-1:0] RECIP_HUND = 14'd41;
   localparam logic [MV_W-1:0] RECIP_TENS = 14'd205;
   localparam logic [MV_W-1:0] SCALE_THOU = 14'd1000;
   localparam logic [MV_W-1:0] SCALE_HUND = 14'd100;
   localparam logic [MV_W-1:0] SCALE_TENS = 14'd10;

   logic               busy_ff, busy_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [MV_W-1:0]    rest_ff, rest_in;
   logic               rsp_tvalid_ff, rsp_tvalid_in;
   logic [BYTE_W-1:0]  rsp_tdata_ff, rsp_tdata_in;
   logic [IDX_W-1:0]   rsp_tuser_ff, rsp_tuser_in;
   logic               rsp_tlast_ff, rsp_tlast_in;

   logic               out_free, emit, finish, load;
   logic [RPROD_W-1:0] rprod;
   logic [3:0]         digit;
   logic [MV_W-1:0]    rest_next;
   logic [BYTE_W-1:0]  char_val;

   assign out_free = !rsp_tvalid_ff || rsp_tready;
   assign emit     = busy_ff && out_free;
   assign finish   = emit && (idx_ff == POS_LAST);
   assign mv_ready = !busy_ff || finish;
   assign load     = mv_in.valid && mv_ready;

   always_comb begin
      rprod     = '0;
      digit     = '0;
      rest_next = rest_ff;
      char_val  = template_char(idx_ff);
      case (idx_ff)
         POS_THOU: begin
            rprod     = {{MV_W{1'b0}}, rest_ff} * {{MV_W{1'b0}}, RECIP_THOU};
            digit     = rprod[26:23];
            rest_next = rest_ff - MV_W'(digit) * SCALE_THOU;
            char_val  = CHAR_ZERO + BYTE_W'(digit);
         end
         POS_HUND: begin
            rprod     = {{MV_W{1'b0}}, rest_ff} * {{MV_W{1'b0}}, RECIP_HUND};
            digit     = rprod[15:12];
            rest_next = rest_ff - MV_W'(digit) * SCALE_HUND;
            char_val  = CHAR_ZERO + BYTE_W'(digit);
         end
         POS_TENS: begin
            rprod     = {{MV_W{1'b0}}, rest_ff} * {{MV_W{1'b0}}, RECIP_TENS};
            digit     = rprod[14:11];
            rest_next = rest_ff - MV_W'(digit) * SCALE_TENS;
            char_val  = CHAR_ZERO + BYTE_W'(digit);
         end
         POS_UNITS: begin
            digit     = rest_ff[3:0];
            char_val  = CHAR_ZERO + BYTE_W'(digit);
         end
         default: begin
            rest_next = rest_ff;
         end
      endcase
   end

   always_comb begin
      busy_in       = busy_ff;
      idx_in        = idx_ff;
      rest_in       = rest_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      rsp_tlast_in  = rsp_tlast_ff;
      if (emit) begin
         rsp_tvalid_in = 1'b1;
         rsp_tdata_in  = char_val;
         rsp_tuser_in  = idx_ff;
         rsp_tlast_in  = (idx_ff == POS_LAST);
         rest_in       = rest_next;
         idx_in        = idx_ff + IDX_W'(1);
         if (finish) begin
            busy_in = 1'b0;
            idx_in  = '0;
         end
      end
      if (load) begin
         busy_in = 1'b1;
         idx_in  = '0;
         rest_in = mv_in.mv;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         idx_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         busy_ff       <= busy_in;
         idx_ff        <= idx_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      rest_ff      <= rest_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
      rsp_tlast_ff <= rsp_tlast_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign rsp_tlast  = rsp_tlast_ff;

`include "adc_millivolt_ascii_reporter_assert.svh"

   `AMAR_ASSERT_SAME(a_last_at_end, clock, reset, rsp_tvalid_ff, rsp_tlast_ff == (rsp_tuser_ff == POS_LAST))
   `AMAR_ASSERT_NEXT(a_run_in_order, clock, reset, rsp_tvalid_ff && rsp_tready && !rsp_tlast_ff, rsp_tvalid_ff && (rsp_tuser_ff == $past(rsp_tuser_ff) + IDX_W'(1)))
   `AMAR_ASSERT_SAME(a_digit_ascii, clock, reset, rsp_tvalid_ff && (rsp_tuser_ff == POS_THOU || rsp_tuser_ff == POS_HUND || rsp_tuser_ff == POS_TENS || rsp_tuser_ff == POS_UNITS), rsp_tdata_ff >= CHAR_ZERO && rsp_tdata_ff <= CHAR_NINE)

endmodule

[rtl/adc_millivolt_ascii_reporter.sv]
// Channel  Direction  Ports                       Contents
// req      in         req_tvalid/tready/tdata     adc_sample [15:0]
// rsp      out        rsp_tvalid/tready/tdata     out_byte [7:0], tuser char_index, tlast last
// csr      in         csr_we/csr_wdata            full_scale_mv [13:0]
//
// Each request yields 15 bytes, one per cycle while rsp_tready is high, set by the single output
// register that the serialiser fills once per byte; it takes the next value with the last byte.
// First byte path: three scaler stages, the serialiser rest register, one output stage.
// Reset clears every valid flag and loads full_scale_mv with 3300.
// rsp_tready low holds the output byte; up to three requests queue in the scaler behind it.
module adc_millivolt_ascii_reporter
   import amar_pkg::*;
#(
   parameter int unsigned SAMPLE_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [ADC_W-1:0]   req_tdata,   // [15:0] adc_sample
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [BYTE_W-1:0]  rsp_tdata,   // [7:0] out_byte
   output logic [IDX_W-1:0]   rsp_tuser,   // [3:0] char_index
   output logic               rsp_tlast,
   input  logic               csr_we,
   input  logic [FS_W-1:0]    csr_wdata
);

   logic [FS_W-1:0] full_scale_ff, full_scale_in;
   amar_mv_type     mv_link;
   logic            mv_ready;

   assign full_scale_in = csr_we ? csr_wdata : full_scale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         full_scale_ff <= FS_RESET;
      end else begin
         full_scale_ff <= full_scale_in;
      end
   end

   amar_scaler #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_scaler (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_sample  (req_tdata),
      .full_scale (full_scale_ff),
      .mv_out     (mv_link),
      .mv_ready   (mv_ready)
   );

   amar_serialiser u_serialiser (
      .clock      (clock),
      .reset      (reset),
      .mv_in      (mv_link),
      .mv_ready   (mv_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

[verif/tb_adc_millivolt_ascii_reporter.sv]
`timescale 1ns / 1ps

module tb_adc_millivolt_ascii_reporter;
   import amar_pkg::*;

   localparam int unsigned SAMPLE_FULL = (1 << ADC_W) - 1;
   localparam int unsigned MSG_CHARS   = 15;
   localparam int unsigned RANDOM_SETS = 6;
   localparam int unsigned SET_SAMPLES = 18;
   localparam logic [8*13-1:0]   BANNER  = "Voltaje:0.000";
   localparam logic [BYTE_W-1:0] CR_CHAR = 8'h0D;
   localparam logic [BYTE_W-1:0] LF_CHAR = 8'h0A;

   typedef struct packed {
      logic [BYTE_W-1:0] ch;
      logic [IDX_W-1:0]  pos;
      logic              last;
   } msg_char_type;

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [ADC_W-1:0]  req_tdata  = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [BYTE_W-1:0] rsp_tdata;
   logic [IDX_W-1:0]  rsp_tuser;
   logic              rsp_tlast;
   logic              csr_we     = 1'b0;
   logic [FS_W-1:0]   csr_wdata  = '0;

   logic [ADC_W-1:0] sample_q [$];
   msg_char_type     char_q [$];
   logic [FS_W-1:0]  full_scale_mv;
   bit               req_taken;
   bit               calm;
   int unsigned      mismatch_count;

   adc_millivolt_ascii_reporter u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [15:0] adc_sample
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // [7:0] out_byte
      .rsp_tuser  (rsp_tuser),   // [3:0] char_index
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   function automatic void predict_message(input logic [ADC_W-1:0] sample,
                                           input logic [FS_W-1:0] fs);
      int unsigned mv;
      logic [BYTE_W-1:0] msg [MSG_CHARS];
      msg_char_type item;
      mv = (int'(sample) * int'(fs)) / SAMPLE_FULL;
      if (mv > MV_MAX) begin
         mv = MV_MAX;
      end
      for (int k = 0; k < 13; k++) begin
         msg[k] = BANNER[8*(12-k) +: 8];
      end
      msg[13] = CR_CHAR;
      msg[14] = LF_CHAR;
      msg[POS_UNITS] = CHAR_ZERO + BYTE_W'(mv % 10);
      msg[POS_TENS]  = CHAR_ZERO + BYTE_W'((mv / 10) % 10);
      msg[POS_HUND]  = CHAR_ZERO + BYTE_W'((mv / 100) % 10);
      msg[POS_THOU]  = CHAR_ZERO + BYTE_W'((mv / 1000) % 10);
      for (int k = 0; k < MSG_CHARS; k++) begin
         item.ch   = msg[k];
         item.pos  = IDX_W'(k);
         item.last = (k == POS_LAST);
         char_q.push_back(item);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         full_scale_mv <= FS_RESET;
      end else if (csr_we) begin
         full_scale_mv <= csr_wdata;
      end
      req_taken = !reset && req_tvalid && req_tready;
      if (req_taken) begin
         predict_message(req_tdata, full_scale_mv);
      end
   end

   // offer the next request once the current one is taken; hold it otherwise
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (sample_q.size() != 0 && (calm || $urandom_range(0, 99) >= 10)) begin
            req_tvalid <= 1'b1;
            req_tdata  <= sample_q.pop_front();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_tready <= !reset && (calm || $urandom_range(0, 99) >= 10);
   end

   always @(posedge clock) begin
      msg_char_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (char_q.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected byte %h index %0d last %b", $time,
                     rsp_tdata, rsp_tuser, rsp_tlast);
         end else begin
            want = char_q.pop_front();
            if (rsp_tdata !== want.ch || rsp_tuser !== want.pos || rsp_tlast !== want.last) begin
               mismatch_count++;
               $display("%0t: expected byte %h index %0d last %b, got %h index %0d last %b",
                        $time, want.ch, want.pos, want.last, rsp_tdata, rsp_tuser, rsp_tlast);
            end
         end
      end
   end

   task automatic wait_idle();
      do @(posedge clock);
      while (sample_q.size() != 0 || req_tvalid || char_q.size() != 0);
   endtask

   task automatic write_full_scale(input logic [FS_W-1:0] value);
      wait_idle();
      repeat (8) @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [ADC_W-1:0] pick_sample();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2:       return ADC_W'($urandom_range(0, 15));
         3:       return ADC_W'(SAMPLE_FULL - $urandom_range(0, 15));
         default: return ADC_W'($urandom_range(0, SAMPLE_FULL));
      endcase
   endfunction

   function automatic logic [FS_W-1:0] pick_full_scale();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return FS_W'($urandom_range(10000, 16383));
         default: return FS_W'($urandom_range(1, 9999));
      endcase
   endfunction

   initial begin
      logic [ADC_W-1:0] opening [9];
      opening = '{16'd0, 16'hFFFF, 16'd1, 16'hFFFE, 16'h7FFF,
                  16'h8000, 16'h5555, 16'hAAAA, 16'd19859};
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (opening[i]) sample_q.push_back(opening[i]);

      write_full_scale(14'h3FFF);
      sample_q = '{16'hFFFF, 16'd40000, 16'd39999, 16'd0};
      write_full_scale(14'd0);
      sample_q = '{16'hFFFF, 16'd12345};
      write_full_scale(14'd1);
      sample_q = '{16'hFFFF, 16'hFFFE};
      write_full_scale(14'd9999);
      sample_q = '{16'hFFFF, 16'd6554};

      for (int p = 0; p < RANDOM_SETS; p++) begin
         write_full_scale(pick_full_scale());
         calm = (p == 2);
         for (int i = 0; i < SET_SAMPLES; i++) begin
            sample_q.push_back(pick_sample());
         end
         wait_idle();
         calm = 1'b0;
      end

      wait_idle();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

[sim.f]
+incdir+rtl
rtl/amar_pkg.sv
rtl/amar_scaler.sv
rtl/amar_serialiser.sv
rtl/adc_millivolt_ascii_reporter.sv
verif/tb_adc_millivolt_ascii_reporter.sv
